[design/rakt_pkg.sv]
// Package for the range-add / k-th take core.
// Holds the item, command and result structs, sizes and the Fenwick-tree low_bit helper. No dependencies.
package rakt_pkg;

  localparam int unsigned IdxW   = 16;
  localparam int unsigned Npos   = 65536;
  localparam int unsigned AddrW  = 17;
  localparam int unsigned CntW   = 17;
  localparam int unsigned AccW   = 64;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TAKE = 1'b1
  } req_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] range_low;
    logic [15:0] range_high;
    logic [7:0]  add_value;
    logic [16:0] rank;
  } req_t;

  typedef struct packed {
    logic [31:0] position_value;
    logic [15:0] position_index;
    logic        found;
  } res_t;

  typedef struct packed {
    logic             take;
    logic             skip;
    logic [AddrW-1:0] lo_addr;
    logic [AddrW-1:0] hi_addr;
    logic             hi_valid;
    logic [7:0]       value;
    logic [16:0]      rank;
  } cmd_t;

  function automatic logic [AddrW-1:0] low_bit(input logic [AddrW-1:0] i);
    return i & (~i + {{(AddrW-1){1'b0}}, 1'b1});
  endfunction

endpackage

[design/rakt_front.sv]
// Front end: accepts items, classifies and clips them, and queues commands.
// Depends on rakt_pkg. Tracks the present count to screen bad ranks.
module rakt_front import rakt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o,
  input  logic cmd_pop_i
);

  cmd_t       q_mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic [CntW:0] total_q;
  logic       acc;
  cmd_t       c;
  logic [16:0] hi_c;

  assign busy = (cnt_q == 2'd2);
  assign acc  = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_mem_q[rd_q];

  always_comb begin
    hi_c = {1'b0, req_i.range_high} + 17'd2;
    c = '0;
    c.take  = (req_i.req_type == REQ_TAKE);
    c.rank  = req_i.rank;
    c.value = req_i.add_value;
    c.lo_addr  = {1'b0, req_i.range_low} + 17'd1;
    c.hi_addr  = hi_c;
    c.hi_valid = (hi_c <= AddrW'(Npos));
    if (c.take) begin
      c.skip = (req_i.rank == 17'd0) || ({1'b0, req_i.rank} > total_q);
    end else begin
      c.skip = (req_i.range_low > req_i.range_high) || (req_i.add_value == 8'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      q_mem_q[wr_q] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= 2'd0;
      total_q <= (CntW+1)'(Npos);
    end else begin
      if (acc) begin
        wr_q <= ~wr_q;
        if (c.take && !c.skip) begin
          total_q <= total_q - (CntW+1)'(1);
        end
      end
      if (cmd_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, cmd_pop_i};
    end
  end

endmodule

[design/rakt_back.sv]
// Back end: walks the two Fenwick trees in memory, one level per read state and the update state after it.
// Depends on rakt_pkg. Clears both trees to their reset image after reset.
module rakt_back import rakt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_ADDR = 4'd2, S_ADDW = 4'd3,
                         S_SRCH = 4'd4, S_SRCW = 4'd5, S_DECR = 4'd6, S_DECW = 4'd7,
                         S_SUMR = 4'd8, S_SUMW = 4'd9, S_DONE = 4'd10;

  logic [AccW-1:0] dif_mem [Npos+1];
  logic [CntW-1:0] cnt_mem [Npos+1];

  logic [3:0]       st_q;
  logic [AddrW-1:0] i_q, pos_q, step_q;
  logic             second_q;
  logic [16:0]      r_q;
  logic [AccW-1:0]  sum_q, dif_rd_q;
  logic [CntW-1:0]  cnt_rd_q;
  logic [AddrW-1:0] rd_addr;
  logic             dif_we, cnt_we;
  logic [AddrW-1:0] wr_addr;
  logic [AccW-1:0]  dif_wd;
  logic [CntW-1:0]  cnt_wd;
  logic [AccW-1:0]  v64;
  logic [AddrW-1:0] nxt;
  logic [AddrW:0]   up_nxt;
  logic             up_ok;

  assign v64 = second_q ? (AccW'(0) - AccW'(cmd_i.value)) : AccW'(cmd_i.value);
  assign nxt = pos_q + step_q;
  assign up_nxt = {1'b0, i_q} + {1'b0, low_bit(i_q)};
  assign up_ok  = (up_nxt <= (AddrW+1)'(Npos));

  always_comb begin
    rd_addr = i_q;
    if (st_q == S_SRCH) begin
      rd_addr = nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    dif_rd_q <= dif_mem[rd_addr];
    cnt_rd_q <= cnt_mem[rd_addr];
    if (dif_we) begin
      dif_mem[wr_addr] <= dif_wd;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wd;
    end
  end

  always_comb begin
    dif_we  = (st_q == S_INIT) || (st_q == S_ADDW);
    dif_wd  = (st_q == S_INIT) ? '0 : (dif_rd_q + v64);
    cnt_we  = (st_q == S_INIT) || (st_q == S_DECW);
    cnt_wd  = (st_q == S_INIT) ? low_bit(i_q) : (cnt_rd_q - CntW'(1));
    wr_addr = i_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_INIT;
      i_q         <= AddrW'(0);
      pos_q       <= '0;
      step_q      <= '0;
      second_q    <= 1'b0;
      r_q         <= '0;
      sum_q       <= '0;
      cmd_pop_o   <= 1'b0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
    end else begin
      cmd_pop_o   <= 1'b0;
      res_valid_o <= 1'b0;
      case (st_q)
        S_INIT: begin
          i_q <= i_q + AddrW'(1);
          if (i_q == AddrW'(Npos)) begin
            st_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid_i && !cmd_pop_o) begin
            if (cmd_i.skip) begin
              if (cmd_i.take) begin
                res_valid_o <= 1'b1;
                res_o       <= '0;
              end
              cmd_pop_o <= 1'b1;
            end else if (cmd_i.take) begin
              pos_q  <= '0;
              step_q <= AddrW'(Npos);
              r_q    <= cmd_i.rank;
              st_q   <= S_SRCH;
            end else begin
              i_q      <= cmd_i.lo_addr;
              second_q <= 1'b0;
              st_q     <= S_ADDR;
            end
          end
        end
        S_ADDR: st_q <= S_ADDW;
        S_ADDW: begin
          if (up_ok) begin
            i_q  <= up_nxt[AddrW-1:0];
            st_q <= S_ADDR;
          end else if (!second_q && cmd_i.hi_valid) begin
            second_q <= 1'b1;
            i_q      <= cmd_i.hi_addr;
            st_q     <= S_ADDR;
          end else begin
            cmd_pop_o <= 1'b1;
            st_q      <= S_IDLE;
          end
        end
        S_SRCH: st_q <= S_SRCW;
        S_SRCW: begin
          if (nxt <= AddrW'(Npos) && 17'(cnt_rd_q) < r_q) begin
            pos_q <= nxt;
            r_q   <= r_q - 17'(cnt_rd_q);
          end
          if (step_q == AddrW'(1)) begin
            i_q  <= ((nxt <= AddrW'(Npos) && 17'(cnt_rd_q) < r_q) ? nxt : pos_q) + AddrW'(1);
            st_q <= S_DECR;
          end else begin
            step_q <= step_q >> 1;
            st_q   <= S_SRCH;
          end
        end
        S_DECR: st_q <= S_DECW;
        S_DECW: begin
          if (up_ok) begin
            i_q  <= up_nxt[AddrW-1:0];
            st_q <= S_DECR;
          end else begin
            i_q   <= pos_q + AddrW'(1);
            sum_q <= '0;
            st_q  <= S_SUMR;
          end
        end
        S_SUMR: st_q <= S_SUMW;
        S_SUMW: begin
          sum_q <= sum_q + dif_rd_q;
          if (i_q - low_bit(i_q) == AddrW'(0)) begin
            st_q <= S_DONE;
          end else begin
            i_q  <= i_q - low_bit(i_q);
            st_q <= S_SUMR;
          end
        end
        S_DONE: begin
          res_valid_o          <= 1'b1;
          res_o.found          <= 1'b1;
          res_o.position_index <= pos_q[IdxW-1:0];
          res_o.position_value <= (sum_q[AccW-1:32] != '0) ? 32'hFFFF_FFFF : sum_q[31:0];
          cmd_pop_o <= 1'b1;
          st_q      <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/range_add_kth_remaining_take_core.sv]
// Top level of the range-add / k-th take core.
// Depends on rakt_pkg, rakt_front and rakt_back.
// Items are accepted when start is high and busy low; up to two wait in a queue.
// A take walks the count tree (17 levels), decrements up to 17 nodes and sums
// up to 16 difference nodes; an add does up to 17 read-modify-writes at the low
// end and 16 at the high end. Both trees sit in memories with a registered read,
// so each node visit takes a read state and then an update state. After reset
// both trees are rebuilt before the first item is carried out; items may queue
// meanwhile. Results appear for one cycle with res_valid_o and cannot be stalled.
module range_add_kth_remaining_take_core import rakt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  rakt_front u_front (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  rakt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .res_valid_o, .res_o
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.found) |-> (res_o.position_value == 32'd0))
    else $error("miss carries a value");

endmodule

[dv/testbench.sv]
// Self-checking testbench for range_add_kth_remaining_take_core.
// It predicts every take result with its own pair of Fenwick trees and
// compares it field by field. Depends on rakt_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import rakt_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 400;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  logic [63:0] diff_tree [0:Npos+1];
  int unsigned count_tree [0:Npos];
  int unsigned present_total;
  res_t taken_q [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned burst_left;

  range_add_kth_remaining_take_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .res_valid_o(res_valid_o),
    .res_o(res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned lsb_of(int unsigned i);
    return i & (~i + 1);
  endfunction

  function automatic void clear_rows();
    for (int unsigned i = 0; i <= Npos + 1; i++) diff_tree[i] = '0;
    count_tree[0] = 0;
    for (int unsigned i = 1; i <= Npos; i++) count_tree[i] = lsb_of(i);
    present_total = Npos;
  endfunction

  function automatic void diff_update(int unsigned idx, logic [63:0] amount);
    int unsigned i;
    i = idx;
    while (i >= 1 && i <= Npos) begin
      diff_tree[i] += amount;
      i += lsb_of(i);
    end
  endfunction

  function automatic void apply_range_add(req_t rq);
    int unsigned lo;
    int unsigned hi;
    lo = rq.range_low;
    hi = rq.range_high;
    if (lo > hi || lo >= Npos || rq.add_value == 0) return;
    if (hi >= Npos) hi = Npos - 1;
    diff_update(lo + 1, {56'd0, rq.add_value});
    diff_update(hi + 2, 64'd0 - {56'd0, rq.add_value});
  endfunction

  function automatic res_t take_ranked_position(logic [16:0] rank);
    int unsigned r;
    int unsigned pos;
    int unsigned stp;
    int unsigned nxt;
    int unsigned i;
    logic [63:0] acc;
    res_t res;
    res = '0;
    r = rank;
    if (r == 0 || r > present_total) return res;
    pos = 0;
    for (stp = Npos; stp != 0; stp >>= 1) begin
      nxt = pos + stp;
      if (nxt <= Npos && count_tree[nxt] < r) begin
        pos = nxt;
        r -= count_tree[nxt];
      end
    end
    for (i = pos + 1; i <= Npos; i += lsb_of(i)) count_tree[i]--;
    present_total--;
    acc = '0;
    for (i = pos + 1; i >= 1; i -= lsb_of(i)) acc += diff_tree[i];
    res.position_value = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    res.position_index = pos[15:0];
    res.found = 1'b1;
    return res;
  endfunction

  task automatic send_beat(req_t rq);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start = 1'b1;
    req_i = rq;
    do @(posedge clk_i); while (busy);
    if (rq.req_type == REQ_TAKE) taken_q.push_back(take_ranked_position(rq.rank));
    else apply_range_add(rq);
  endtask

  task automatic idle_start();
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic send_add(int unsigned lo, int unsigned hi, int unsigned val);
    req_t rq;
    rq = '0;
    rq.req_type = REQ_ADD;
    rq.range_low = lo[15:0];
    rq.range_high = hi[15:0];
    rq.add_value = val[7:0];
    rq.rank = 17'($urandom);
    send_beat(rq);
  endtask

  task automatic send_take(int unsigned rank);
    req_t rq;
    rq = '0;
    rq.req_type = REQ_TAKE;
    rq.rank = rank[16:0];
    rq.range_low = 16'($urandom);
    rq.range_high = 16'($urandom);
    rq.add_value = 8'($urandom);
    send_beat(rq);
  endtask

  task automatic wait_results_done();
    idle_start();
    while (taken_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_edges();
    send_take(Npos);
    send_take(Npos);
    send_take(0);
    send_add(0, 65535, 255);
    send_add(0, 65535, 0);
    send_add(10, 9, 200);
    send_add(65535, 65535, 7);
    send_add(0, 0, 1);
    send_add(100, 200, 128);
    send_take(1);
    send_take(present_total);
    send_take(present_total + 1);
    send_take(101);
    send_add(65535, 0, 99);
    send_add(300, 300, 255);
    send_take(300);
    send_take(present_total / 2);
    send_take(Npos - 1);
  endtask

  task automatic test_drain_pause();
    wait_results_done();
    send_take(2);
    send_add(5, 50, 33);
    send_take(5);
    wait_results_done();
  endtask

  task automatic test_random_mix(int unsigned n_items);
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    for (int unsigned k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        lo = $urandom_range(0, 65535);
        pick = $urandom_range(0, 9);
        if (pick == 0) hi = $urandom_range(0, 65535);
        else if (pick == 1) begin
          lo = $urandom_range(0, 32);
          hi = $urandom_range(65500, 65535);
        end else begin
          hi = lo + $urandom_range(0, 64);
          if (hi > 65535) hi = 65535;
        end
        send_add(lo, hi, ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255));
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_take(0);
        else if (pick == 1) send_take($urandom_range(present_total + 1, Npos));
        else if (pick == 2) send_take(present_total);
        else send_take($urandom_range(1, present_total));
      end
      if ($urandom_range(0, 49) == 0) idle_start();
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (taken_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result beat: %p", res_o);
      end else begin
        want = taken_q.pop_front();
        if (res_o.found !== want.found || res_o.position_index !== want.position_index ||
            res_o.position_value !== want.position_value) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: expected %p, actual %p", want, res_o);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    clear_rows();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_edges();
    test_drain_pause();
    test_random_mix(450);
    wait_results_done();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && taken_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
